// ===== hw/rtl/fa2_pkg.sv =====
// Package for the fixed-point atan2 block: widths, Q16 and Q13 constants and stage payload types.
// No dependencies.
package fa2_pkg;

    localparam int CompWidth  = 16;
    localparam int MagWidth   = CompWidth + 1;
    localparam int AngleWidth = 16;
    localparam int AngleFrac  = 13;
    localparam int QBits      = 17;
    localparam int AccWidth   = 20;

    localparam logic [15:0] KPi4 = 16'd51472;
    localparam logic [15:0] KC1  = 16'd16037;
    localparam logic [15:0] KC2  = 16'd4345;
    localparam logic signed [AccWidth-1:0] KPi2 = 20'sd102944;
    localparam logic signed [AccWidth-1:0] KPi  = 20'sd205887;
    localparam logic signed [AngleWidth-1:0] AngleLim = 16'sd25736;

    // Offset applied after the polynomial.
    typedef enum logic [2:0] {
        OFS_NONE,
        OFS_PLUS_PI2,
        OFS_MINUS_PI2,
        OFS_PLUS_PI,
        OFS_MINUS_PI
    } offset_t;

    // Side information that travels with each item through the pipeline.
    typedef struct packed {
        logic    zero;
        logic    neg;      // ratio is negative
        logic    sub;      // angle = offset - atan instead of offset + atan
        offset_t ofs;
    } ctrl_t;

endpackage

// ===== hw/rtl/fa2_if.sv =====
// Valid/ready stream interface carrying a payload of configurable type.
// Depends on nothing.
interface fa2_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fa2_divider.sv =====
// Pipelined restoring divider: numerator/denominator to a Q16 ratio, 17 quotient bits.
// Depends on fa2_pkg. Each stage resolves one quotient bit; enable stalls the pipe.
module fa2_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [fa2_pkg::MagWidth-1:0]       num,
    input  logic [fa2_pkg::MagWidth-1:0]       den,
    input  fa2_pkg::ctrl_t                     in_ctrl,
    output logic                               out_valid,
    output logic [fa2_pkg::QBits-1:0]          quo,
    output fa2_pkg::ctrl_t                     out_ctrl
);
    localparam int N = fa2_pkg::QBits;
    localparam int RW = fa2_pkg::MagWidth + 1;

    logic [N:0]                          v_reg;
    logic [RW-1:0]                       rem_reg [N+1];
    logic [fa2_pkg::MagWidth-1:0]        den_reg [N+1];
    logic [N-1:0]                        q_reg   [N+1];
    fa2_pkg::ctrl_t                      c_reg   [N+1];

    // Stage 0 registers the operands; stage k computes quotient bit N-k.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, num};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            c_reg[0]   <= in_ctrl;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_stage
        logic [RW-1:0] trial;
        logic [RW:0]   diff;
        assign trial = (k == 1) ? rem_reg[k-1] : {rem_reg[k-1][RW-2:0], 1'b0};
        assign diff  = {1'b0, trial} - {2'b00, den_reg[k-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= diff[RW] ? trial : diff[RW-1:0];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][N-2:0], ~diff[RW]};
                c_reg[k]   <= c_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign quo       = q_reg[N];
    assign out_ctrl  = c_reg[N];
endmodule

// ===== hw/rtl/fa2_poly.sv =====
// Polynomial atan stages, offset, rescale and saturation.
// Depends on fa2_pkg. Four register stages, stalled by en.
module fa2_poly (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [fa2_pkg::QBits-1:0]         a,
    input  fa2_pkg::ctrl_t                    in_ctrl,
    output logic                              out_valid,
    output logic signed [fa2_pkg::AngleWidth-1:0] angle,
    output logic                              undef
);
    localparam int AW = fa2_pkg::AccWidth;

    logic [3:0]      v_reg;
    fa2_pkg::ctrl_t  c1_reg, c2_reg, c3_reg;
    logic [16:0]     u_reg;
    logic [15:0]     q_reg;
    logic [16:0]     lin_reg;
    logic [16:0]     f_reg;
    logic signed [AW-1:0] ang_reg;
    logic signed [fa2_pkg::AngleWidth-1:0] angle_reg;
    logic            undef_reg;

    logic [17:0] a_clip;
    logic [33:0] p_u;
    logic [32:0] p_l;
    logic [32:0] p_q;
    logic [32:0] p_uq;
    logic signed [AW-1:0] f_s, ofs, ang_next;
    logic signed [AW-1:0] scaled;
    logic signed [AW-1:0] lim;

    always_comb
    begin
        a_clip = {1'b0, a};
        p_u    = a_clip * (18'd65536 - a_clip);
        p_l    = 33'(fa2_pkg::KPi4) * 33'(a);
        p_q    = 33'(fa2_pkg::KC2) * 33'(a);
        p_uq   = 33'(u_reg) * 33'(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_comb
    begin
        f_s = AW'(signed'({1'b0, f_reg}));
        case (c2_reg.ofs)
            fa2_pkg::OFS_PLUS_PI2:  ofs = fa2_pkg::KPi2;
            fa2_pkg::OFS_MINUS_PI2: ofs = -fa2_pkg::KPi2;
            fa2_pkg::OFS_PLUS_PI:   ofs = fa2_pkg::KPi;
            fa2_pkg::OFS_MINUS_PI:  ofs = -fa2_pkg::KPi;
            default:                ofs = '0;
        endcase
        // Signed atan is neg ? -f : f; the x/y branches subtract it from the offset.
        if (c2_reg.neg ^ c2_reg.sub)
            ang_next = ofs - f_s;
        else
            ang_next = ofs + f_s;
        // Floor shift to Q13.
        scaled = ang_reg >>> (16 - fa2_pkg::AngleFrac);
        lim    = AW'(fa2_pkg::AngleLim);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= in_ctrl;
            u_reg    <= p_u[32:16];
            q_reg    <= fa2_pkg::KC1 + p_q[31:16];
            lin_reg  <= p_l[32:16];
            c2_reg   <= c1_reg;
            f_reg    <= lin_reg + p_uq[32:16];
            c3_reg   <= c2_reg;
            ang_reg  <= ang_next;
            undef_reg <= c3_reg.zero;
            if (c3_reg.zero)
                angle_reg <= '0;
            else if (scaled > lim)
                angle_reg <= fa2_pkg::AngleLim;
            else if (scaled < -lim)
                angle_reg <= -fa2_pkg::AngleLim;
            else
                angle_reg <= scaled[fa2_pkg::AngleWidth-1:0];
        end
    end

    assign out_valid = v_reg[3];
    assign angle     = angle_reg;
    assign undef     = undef_reg;

    property p_undef_zero;
        @(posedge clk) disable iff (!rst_n) (out_valid && undef) |-> (angle == '0);
    endproperty
    a_undef_zero: assert property (p_undef_zero) else $error("zero vector angle not 0");

    property p_sat;
        @(posedge clk) disable iff (!rst_n)
            out_valid |-> (angle <= fa2_pkg::AngleLim && angle >= -fa2_pkg::AngleLim);
    endproperty
    a_sat: assert property (p_sat) else $error("angle outside saturation range");

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n) !en |=> $stable(v_reg) && $stable(angle_reg);
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("pipe moved during stall");
endmodule

// ===== hw/rtl/fast_atan2_approx.sv =====
// Fixed-point atan2: octant select, pipelined divider, polynomial and saturation.
// Throughput: one beat per cycle; the whole pipe stalls while the output beat waits.
// Reset: rst_n asynchronously clears every valid bit; payload registers are not reset.
// Depends on fa2_pkg, fa2_if, fa2_divider and fa2_poly.
module fast_atan2_approx (
    input logic clk,
    input logic rst_n,
    fa2_if.sink   in_ch,
    fa2_if.source out_ch
);
    localparam int CW = fa2_pkg::CompWidth;
    localparam int MW = fa2_pkg::MagWidth;

    logic signed [CW-1:0] y, x;
    logic [MW-1:0] ay, ax, num, den;
    fa2_pkg::ctrl_t ctrl;
    logic en;
    logic dv, pv;
    logic [fa2_pkg::QBits-1:0] quo;
    fa2_pkg::ctrl_t dctrl;
    logic signed [fa2_pkg::AngleWidth-1:0] angle;
    logic undef;

    assign y  = in_ch.data.y_in;
    assign x  = in_ch.data.x_in;
    assign ay = y[CW-1] ? MW'(-{y[CW-1], y}) : {1'b0, y};
    assign ax = x[CW-1] ? MW'(-{x[CW-1], x}) : {1'b0, x};

    always_comb
    begin
        ctrl.zero = (x == '0) && (y == '0);
        ctrl.neg  = 1'b0;
        ctrl.sub  = 1'b0;
        ctrl.ofs  = fa2_pkg::OFS_NONE;
        if (ay < ax)
        begin
            num = ay;
            den = ax;
            ctrl.neg = y[CW-1] ^ x[CW-1];
            if (x[CW-1])
                ctrl.ofs = y[CW-1] ? fa2_pkg::OFS_MINUS_PI : fa2_pkg::OFS_PLUS_PI;
        end
        else
        begin
            num = ax;
            den = ay;
            ctrl.sub = 1'b1;
            ctrl.neg = x[CW-1] ^ y[CW-1];
            ctrl.ofs = y[CW-1] ? fa2_pkg::OFS_MINUS_PI2 : fa2_pkg::OFS_PLUS_PI2;
        end
        if (ctrl.zero)
        begin
            den = MW'(1);
            num = '0;
        end
    end

    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    fa2_divider u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
        .num(num), .den(den), .in_ctrl(ctrl),
        .out_valid(dv), .quo(quo), .out_ctrl(dctrl)
    );

    fa2_poly u_poly (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv), .a(quo), .in_ctrl(dctrl),
        .out_valid(pv), .angle(angle), .undef(undef)
    );

    assign out_ch.valid                 = pv;
    assign out_ch.data.angle            = angle;
    assign out_ch.data.undefined_vector = undef;

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("output beat changed while stalled");

    property p_ready;
        @(posedge clk) disable iff (!rst_n) !out_ch.valid |-> in_ch.ready;
    endproperty
    a_ready: assert property (p_ready) else $error("input blocked with empty output");

    property p_undef_flag;
        @(posedge clk) disable iff (!rst_n)
            (out_ch.valid && out_ch.data.undefined_vector) |-> out_ch.data.angle == '0;
    endproperty
    a_undef_flag: assert property (p_undef_flag) else $error("undefined vector angle");
endmodule
